@@ sv/slu_pkg.sv @@
`default_nettype none
package slu_pkg;

    localparam int LIST_DEPTH  = 32;
    localparam int VALUE_W     = 64;
    localparam int COUNT_W     = 7;
    localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FILL_W      = $clog2(LIST_DEPTH + 1);
    localparam int TOTAL_W     = $clog2(2 * LIST_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command from the front to the back: an optional store write and an
    // optional run start, both produced by one input transaction.
    typedef struct packed {
        logic               wr;
        logic               sel;
        logic [IDX_W-1:0]   addr;
        logic [VALUE_W-1:0] value;
        logic               run;
        logic [FILL_W-1:0]  fill_a;
        logic [FILL_W-1:0]  fill_b;
        logic               dropped;
    } cmd_t;

endpackage
`default_nettype wire

@@ sv/slu_ifs.sv @@
`default_nettype none
interface slu_item_if;
    logic               valid;
    logic               ready;
    logic               list_select;
    logic signed [63:0] element_value;
    logic               closes_list;
    logic               carries_no_element;

    modport source (
        output valid, list_select, element_value, closes_list, carries_no_element,
        input  ready
    );
    modport sink (
        input  valid, list_select, element_value, closes_list, carries_no_element,
        output ready
    );
endinterface

interface slu_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] union_value;
    logic               value_valid;
    logic               last_of_run;
    logic [6:0]         union_count;
    logic               overflow_seen;

    modport source (
        output valid, union_value, value_valid, last_of_run, union_count, overflow_seen,
        input  ready
    );
    modport sink (
        input  valid, union_value, value_valid, last_of_run, union_count, overflow_seen,
        output ready
    );
endinterface
`default_nettype wire

@@ sv/slu_front.sv @@
`default_nettype none
module slu_front
    import slu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    slu_item_if.sink   items,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  wire logic  cmd_ready
);

    logic [FILL_W-1:0] fill_a_reg, fill_a_next;
    logic [FILL_W-1:0] fill_b_reg, fill_b_next;
    logic              closed_a_reg, closed_a_next;
    logic              closed_b_reg, closed_b_next;
    logic              dropped_reg, dropped_next;

    logic              accept;
    logic              active;
    logic              sel;
    logic [FILL_W-1:0] cur_fill;
    logic              cur_closed;
    logic              has_elem;
    logic              do_wr;
    logic              do_drop;
    logic              run;

    assign items.ready = cmd_ready;
    assign accept      = items.valid && items.ready;
    assign sel         = items.list_select;
    assign cur_fill    = sel ? fill_b_reg : fill_a_reg;
    assign cur_closed  = sel ? closed_b_reg : closed_a_reg;
    assign active      = accept && !cur_closed;   // items for a closed list are dropped
    assign has_elem    = !items.carries_no_element;
    assign do_wr       = has_elem && (cur_fill < FILL_W'(LIST_DEPTH));
    assign do_drop     = has_elem && !do_wr;

    always_comb
    begin
        fill_a_next   = fill_a_reg + FILL_W'(!sel && do_wr);
        fill_b_next   = fill_b_reg + FILL_W'(sel && do_wr);
        closed_a_next = closed_a_reg || (!sel && items.closes_list);
        closed_b_next = closed_b_reg || (sel && items.closes_list);
        dropped_next  = dropped_reg || do_drop;
        run           = closed_a_next && closed_b_next;

        cmd.wr      = do_wr;
        cmd.sel     = sel;
        cmd.addr    = cur_fill[IDX_W-1:0];
        cmd.value   = items.element_value;
        cmd.run     = run;
        cmd.fill_a  = fill_a_next;
        cmd.fill_b  = fill_b_next;
        cmd.dropped = dropped_next;
        cmd_valid   = active && (do_wr || run);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_a_reg   <= '0;
            fill_b_reg   <= '0;
            closed_a_reg <= 1'b0;
            closed_b_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else if (active)
        begin
            if (run)
            begin
                // the run is handed to the back; start collecting the next pair
                fill_a_reg   <= '0;
                fill_b_reg   <= '0;
                closed_a_reg <= 1'b0;
                closed_b_reg <= 1'b0;
                dropped_reg  <= 1'b0;
            end
            else
            begin
                fill_a_reg   <= fill_a_next;
                fill_b_reg   <= fill_b_next;
                closed_a_reg <= closed_a_next;
                closed_b_reg <= closed_b_next;
                dropped_reg  <= dropped_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/slu_cmd_queue.sv @@
`default_nettype none
module slu_cmd_queue
    import slu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire cmd_t  in_cmd,
    output logic       in_ready,
    output logic       out_valid,
    output cmd_t       out_cmd,
    input  wire logic  out_ready
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign in_ready  = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule
`default_nettype wire

@@ sv/slu_back.sv @@
`default_nettype none
module slu_back
    import slu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    input  wire cmd_t    cmd,
    output logic         cmd_ready,
    slu_result_if.source results
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_CNT_LOAD  = 3'd1;
    localparam logic [2:0] ST_CNT       = 3'd2;
    localparam logic [2:0] ST_EMIT_LOAD = 3'd3;
    localparam logic [2:0] ST_EMIT      = 3'd4;

    logic [VALUE_W-1:0] mem_a [LIST_DEPTH];
    logic [VALUE_W-1:0] mem_b [LIST_DEPTH];
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;

    logic [2:0]         state_reg, state_next;
    logic [FILL_W-1:0]  i_reg, i_next;
    logic [FILL_W-1:0]  j_reg, j_next;
    logic [FILL_W-1:0]  fa_reg, fa_next;
    logic [FILL_W-1:0]  fb_reg, fb_next;
    logic [FILL_W-1:0]  eq_reg, eq_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] k_reg, k_next;
    logic               drop_reg, drop_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_vv_reg, out_vv_next;
    logic               out_last_reg, out_last_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_drop_reg, out_drop_next;

    logic               pop;
    logic               a_avail, b_avail, same, a_less, take_a, take_b;
    logic               out_free, is_last;

    assign pop      = cmd_valid && cmd_ready;
    assign a_avail  = i_reg < fa_reg;
    assign b_avail  = j_reg < fb_reg;
    assign same     = rd_a_reg == rd_b_reg;
    assign a_less   = $signed(rd_a_reg) < $signed(rd_b_reg);
    assign take_a   = a_avail && (!b_avail || same || a_less);
    assign take_b   = b_avail && (!a_avail || same || !a_less);
    assign out_free = !out_valid_reg || results.ready;
    assign is_last  = (k_reg + TOTAL_W'(1)) == total_reg;

    assign cmd_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        eq_next        = eq_reg;
        total_next     = total_reg;
        k_next         = k_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_value_next = out_value_reg;
        out_vv_next    = out_vv_reg;
        out_last_next  = out_last_reg;
        out_count_next = out_count_reg;
        out_drop_next  = out_drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop && cmd.run)
                begin
                    fa_next    = cmd.fill_a;
                    fb_next    = cmd.fill_b;
                    drop_next  = cmd.dropped;
                    state_next = ST_CNT_LOAD;
                end
            end
            ST_CNT_LOAD:
            begin
                i_next     = '0;
                j_next     = '0;
                eq_next    = '0;
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                // count pass: only the equal pairs matter for the union size
                if (a_avail && b_avail)
                begin
                    i_next  = i_reg + FILL_W'(take_a);
                    j_next  = j_reg + FILL_W'(take_b);
                    eq_next = eq_reg + FILL_W'(same);
                end
                else
                begin
                    total_next = TOTAL_W'(fa_reg) + TOTAL_W'(fb_reg) - TOTAL_W'(eq_reg);
                    state_next = ST_EMIT_LOAD;
                end
            end
            ST_EMIT_LOAD:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (total_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_vv_next    = 1'b0;
                        out_last_next  = 1'b1;
                        out_count_next = '0;
                        out_drop_next  = drop_reg;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = take_a ? rd_a_reg : rd_b_reg;
                    out_vv_next    = 1'b1;
                    out_last_next  = is_last;
                    out_count_next = COUNT_W'(total_reg);
                    out_drop_next  = drop_reg;
                    i_next         = i_reg + FILL_W'(take_a);
                    j_next         = j_reg + FILL_W'(take_b);
                    k_next         = k_reg + TOTAL_W'(1);
                    if (is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            fa_reg        <= '0;
            fb_reg        <= '0;
            eq_reg        <= '0;
            total_reg     <= '0;
            k_reg         <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            fa_reg        <= fa_next;
            fb_reg        <= fb_next;
            eq_reg        <= eq_next;
            total_reg     <= total_next;
            k_reg         <= k_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_vv_reg    <= out_vv_next;
        out_last_reg  <= out_last_next;
        out_count_reg <= out_count_next;
        out_drop_reg  <= out_drop_next;
    end

    // list stores; the read data always tracks the head indexes of the next cycle
    always_ff @(posedge clk)
    begin
        if (pop && cmd.wr && !cmd.sel)
            mem_a[cmd.addr] <= cmd.value;
        rd_a_reg <= mem_a[i_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pop && cmd.wr && cmd.sel)
            mem_b[cmd.addr] <= cmd.value;
        rd_b_reg <= mem_b[j_next[IDX_W-1:0]];
    end

    assign results.valid         = out_valid_reg;
    assign results.union_value   = out_value_reg;
    assign results.value_valid   = out_vv_reg;
    assign results.last_of_run   = out_last_reg;
    assign results.union_count   = out_count_reg;
    assign results.overflow_seen = out_drop_reg;

endmodule
`default_nettype wire

@@ sv/sorted_list_union_merge_unit.sv @@
// Channel   Dir   Payload                                                      Handshake
// items     in    list_select, element_value, closes_list, carries_no_element valid/ready
// results   out   union_value, value_valid, last_of_run, union_count,          valid/ready
//                 overflow_seen
//
// Each item is taken while the command queue has room; the back writes its
// element into its list store when it pops the command, which it does only while idle.
// A run in the back loads its indexes, makes a count pass, loads them again,
// then makes one merge step per result (one empty result if the union is
// empty), each step bounded by one registered read of each list store.
// rst_n clears all control state; the stores need no clearing.
// A stalled result holds the merge; items keep arriving until the queue fills.
`default_nettype none
module sorted_list_union_merge_unit
    import slu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    slu_item_if.sink     items,
    slu_result_if.source results
);

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    slu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    slu_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_cmd    (front_cmd),
        .in_ready  (front_ready),
        .out_valid (back_valid),
        .out_cmd   (back_cmd),
        .out_ready (back_ready)
    );

    slu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_ready (back_ready),
        .results   (results)
    );

endmodule
`default_nettype wire
